// ===== src/ss2d_pkg.sv =====
// shared types, constants and widths of the stencil sparsity generator
package ss2d_pkg;

  localparam int MAX_SPECIES = 16;
  localparam int MAX_DIM     = 1024;

  localparam int SP_W    = 4;
  localparam int POS_W   = 10;
  localparam int DIM_W   = 11;
  localparam int NS_W    = $clog2(MAX_SPECIES + 1);
  localparam int COL_W   = 25;
  localparam int PTR_W   = 29;
  localparam int CFG_W   = 29;
  localparam int IDX_W   = 3;
  localparam int NT_W    = 21;
  localparam int JNY_W   = 20;
  localparam int OFF_W   = 21;
  localparam int NSLOT   = 9;
  localparam int SLOT_W  = 4;
  localparam int NCNT_W  = 5;
  localparam int QDEPTH  = 2;

  localparam logic [PTR_W-1:0] CNT_LIMIT    = PTR_W'(536870910);
  localparam logic [PTR_W-1:0] CAP_RESET    = PTR_W'(402653184);

  typedef enum logic [IDX_W-1:0] {
    REG_SPECIES  = 3'd0,
    REG_X_SIZE   = 3'd1,
    REG_Y_SIZE   = 3'd2,
    REG_WRAP_X   = 3'd3,
    REG_WRAP_Y   = 3'd4,
    REG_CAPACITY = 3'd5
  } cfg_reg_t;

  // neighbor slots in emit order, also the bit positions of the slot mask
  typedef enum logic [SLOT_W-1:0] {
    SLOT_SELF  = 4'd0,
    SLOT_YP    = 4'd1,
    SLOT_XP    = 4'd2,
    SLOT_XM    = 4'd3,
    SLOT_YM    = 4'd4,
    SLOT_WX_LO = 4'd5,
    SLOT_WX_HI = 4'd6,
    SLOT_WY_LO = 4'd7,
    SLOT_WY_HI = 4'd8
  } slot_t;

  typedef struct packed {
    logic [NS_W-1:0]  ns;
    logic [DIM_W-1:0] nx;
    logic [DIM_W-1:0] ny;
    logic             wrap_x;
    logic             wrap_y;
    logic [PTR_W-1:0] cap;
    logic [NT_W-1:0]  nt;
  } cfg_t;

  typedef struct packed {
    logic             ovf;
    logic [PTR_W-1:0] ptr;
    logic [COL_W-1:0] m;
    logic [OFF_W-1:0] off;
    logic [POS_W-1:0] kk;
    logic [JNY_W-1:0] jny;
    logic [NSLOT-1:0] mask;
    logic [SP_W-1:0]  sp;
  } entry_t;

endpackage

// ===== src/ss2d_front.sv =====
// front end: takes cells, clamps them, updates the entry count and builds queue entries
module ss2d_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ss2d_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ss2d_pkg::SP_W-1:0]  in_species,
  input  logic [ss2d_pkg::POS_W-1:0] in_x_pos,
  input  logic [ss2d_pkg::POS_W-1:0] in_y_pos,
  input  logic                     in_restart,
  input  logic                     q_full,
  output logic                     q_push,
  output ss2d_pkg::entry_t         q_data
);
  import ss2d_pkg::*;

  localparam int PROD_W = POS_W + DIM_W;

  logic             s1_valid_r;
  logic             ovf_r;
  logic [PTR_W-1:0] ptr_r;
  logic [SP_W-1:0]  sp_r;
  logic [POS_W-1:0] kk_r;
  logic [JNY_W-1:0] jny_r;
  logic [NSLOT-1:0] mask_r;
  logic [PTR_W-1:0] cnt_r;

  logic             accept;
  logic [SP_W-1:0]  sp_c;
  logic [POS_W-1:0] j_c;
  logic [POS_W-1:0] kk_c;
  logic [PROD_W-1:0] jny_full;
  logic [NSLOT-1:0] mask;
  logic [NCNT_W-1:0] n;
  logic [PTR_W-1:0] cnt_base;
  logic             ovf;
  logic [PTR_W:0]   sum;
  logic [PTR_W-1:0] cnt_new;
  logic [COL_W-1:0] base;

  assign in_stall = s1_valid_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = s1_valid_r & ~q_full;

  always_comb begin
    sp_c = ({1'b0, in_species} >= cfg.ns) ? SP_W'(cfg.ns - NS_W'(1)) : in_species;
    j_c  = ({1'b0, in_x_pos} >= cfg.nx) ? POS_W'(cfg.nx - DIM_W'(1)) : in_x_pos;
    kk_c = ({1'b0, in_y_pos} >= cfg.ny) ? POS_W'(cfg.ny - DIM_W'(1)) : in_y_pos;
    jny_full = PROD_W'(j_c) * PROD_W'(cfg.ny);

    mask             = '0;
    mask[SLOT_SELF]  = 1'b1;
    mask[SLOT_YP]    = (DIM_W'(kk_c) + DIM_W'(1)) < cfg.ny;
    mask[SLOT_XP]    = (DIM_W'(j_c) + DIM_W'(1)) < cfg.nx;
    mask[SLOT_XM]    = j_c != '0;
    mask[SLOT_YM]    = kk_c != '0;
    mask[SLOT_WX_LO] = cfg.wrap_x & (j_c == '0);
    mask[SLOT_WX_HI] = cfg.wrap_x & (DIM_W'(j_c) == cfg.nx - DIM_W'(1));
    mask[SLOT_WY_LO] = cfg.wrap_y & (kk_c == '0);
    mask[SLOT_WY_HI] = cfg.wrap_y & (DIM_W'(kk_c) == cfg.ny - DIM_W'(1));

    n = NCNT_W'($countones(mask)) + NCNT_W'(cfg.ns) - NCNT_W'(1);

    cnt_base = in_restart ? '0 : cnt_r;
    ovf      = cnt_base > cfg.cap;
    sum      = {1'b0, cnt_base} + (PTR_W+1)'(n);
    if (ovf) begin
      cnt_new = cnt_base;
    end else if (sum > {1'b0, CNT_LIMIT}) begin
      cnt_new = CNT_LIMIT;
    end else begin
      cnt_new = sum[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        cnt_r      <= cnt_new;
      end else if (q_push) begin
        s1_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      ovf_r  <= ovf;
      ptr_r  <= cnt_new + PTR_W'(1);
      sp_r   <= sp_c;
      kk_r   <= kk_c;
      jny_r  <= jny_full[JNY_W-1:0];
      mask_r <= mask;
    end
  end

  // species offset of the cell, product registered operands only
  assign base = COL_W'(sp_r) * COL_W'(cfg.nt);

  always_comb begin
    q_data      = '0;
    q_data.ovf  = ovf_r;
    q_data.ptr  = ptr_r;
    q_data.m    = base + COL_W'(jny_r) + COL_W'(kk_r) + COL_W'(1);
    q_data.off  = OFF_W'(jny_r) + OFF_W'(kk_r) + OFF_W'(1);
    q_data.kk   = kk_r;
    q_data.jny  = jny_r;
    q_data.mask = mask_r;
    q_data.sp   = sp_r;
  end

endmodule

// ===== src/ss2d_fifo.sv =====
// short entry queue between the front end and the emitter
module ss2d_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ss2d_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output ss2d_pkg::entry_t pop_data
);
  import ss2d_pkg::*;

  localparam int QA_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W = $clog2(QDEPTH + 1);

  entry_t            mem_r [QDEPTH];
  logic [QA_W-1:0]   wr_ptr_r;
  logic [QA_W-1:0]   rd_ptr_r;
  logic [QC_W-1:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = count_r == QC_W'(QDEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QA_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QA_W'(1);
      end
      if (do_push & ~do_pop) begin
        count_r <= count_r + QC_W'(1);
      end else if (do_pop & ~do_push) begin
        count_r <= count_r - QC_W'(1);
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/ss2d_back.sv =====
// emitter: walks the neighbor slots and other species of an entry, one column a cycle unless stalled
module ss2d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ss2d_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  input  ss2d_pkg::entry_t           q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ss2d_pkg::COL_W-1:0] out_column_index,
  output logic [ss2d_pkg::PTR_W-1:0] out_row_end_pointer,
  output logic                       out_overflow,
  output logic                       out_last
);
  import ss2d_pkg::*;

  function automatic slot_t lowest_slot(input logic [NSLOT-1:0] msk);
    slot_t s;
    s = SLOT_SELF;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (msk[i]) s = slot_t'(i);
    end
    return s;
  endfunction

  entry_t            cur_r;
  logic              busy_r;
  logic [NSLOT-1:0]  mask_r;
  logic [NS_W-1:0]   l_r;
  logic [COL_W-1:0]  sc_r;

  logic              out_valid_r;
  logic [COL_W-1:0]  col_r;
  logic [PTR_W-1:0]  rptr_r;
  logic              ovf_r;
  logic              last_r;

  logic              out_adv;
  logic              gen;
  slot_t             slot;
  logic [NSLOT-1:0]  mask_clr;
  logic [COL_W-1:0]  ny_c;
  logic [COL_W-1:0]  nt_c;
  logic [COL_W-1:0]  col;
  logic              emit_last;
  logic              species_any;
  logic [NS_W-1:0]   l_inc;
  logic              skip;
  logic [NS_W-1:0]   l_next;
  logic              load;

  assign out_adv     = ~out_valid_r | ~out_stall;
  assign gen         = busy_r & out_adv;
  assign ny_c        = COL_W'(cfg.ny);
  assign nt_c        = COL_W'(cfg.nt);
  assign species_any = cfg.ns > NS_W'(1);
  assign slot        = lowest_slot(mask_r);
  assign mask_clr    = mask_r & ~(NSLOT'(1) << slot);
  assign l_inc       = l_r + NS_W'(1);
  assign skip        = l_inc == NS_W'(cur_r.sp);
  assign l_next      = skip ? l_r + NS_W'(2) : l_inc;

  always_comb begin
    col       = cur_r.m;
    emit_last = 1'b0;
    if (cur_r.ovf) begin
      col       = '0;
      emit_last = 1'b1;
    end else if (mask_r != '0) begin
      case (slot)
        SLOT_SELF:  col = cur_r.m;
        SLOT_YP:    col = cur_r.m + COL_W'(1);
        SLOT_XP:    col = cur_r.m + ny_c;
        SLOT_XM:    col = cur_r.m - ny_c;
        SLOT_YM:    col = cur_r.m - COL_W'(1);
        SLOT_WX_LO: col = cur_r.m + nt_c - ny_c;
        SLOT_WX_HI: col = cur_r.m - COL_W'(cur_r.jny);
        SLOT_WY_LO: col = cur_r.m + ny_c - COL_W'(1);
        SLOT_WY_HI: col = cur_r.m - COL_W'(cur_r.kk);
        default:    col = cur_r.m;
      endcase
      emit_last = (mask_clr == '0) & ~species_any;
    end else begin
      col       = sc_r;
      emit_last = l_next >= cfg.ns;
    end
  end

  assign load  = q_valid & (~busy_r | (gen & emit_last));
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (gen & emit_last) begin
        busy_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= gen;
      end
    end

    if (load) begin
      cur_r  <= q_data;
      mask_r <= q_data.mask;
      // first other species skips the cell's own species
      l_r    <= (q_data.sp == '0) ? NS_W'(1) : '0;
      sc_r   <= COL_W'(q_data.off) + ((q_data.sp == '0) ? nt_c : '0);
    end else if (gen & ~cur_r.ovf) begin
      if (mask_r != '0) begin
        mask_r <= mask_clr;
      end else begin
        l_r  <= l_next;
        sc_r <= sc_r + (skip ? {nt_c[COL_W-2:0], 1'b0} : nt_c);
      end
    end

    if (gen) begin
      col_r  <= col;
      rptr_r <= emit_last ? cur_r.ptr : '0;
      ovf_r  <= cur_r.ovf;
      last_r <= emit_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_column_index    = col_r;
  assign out_row_end_pointer = rptr_r;
  assign out_overflow        = ovf_r;
  assign out_last            = last_r;

endmodule

// ===== src/stencil_sparsity_2d_unit.sv =====
// top level of the 2-D five-point stencil sparsity pattern generator
// path: the first result of a cell passes the front end register, the entry queue,
// the emitter's entry register and the output register
// throughput: one result per cycle while out_stall is low; a cell has 1 to 20 results,
// all made by the single column emitter of the back end
// reset (synchronous, rst_n low): entry count cleared, queue and pipeline empty,
// registers back to species 1, grid 1 x 1, no wrap, capacity 402653184
module stencil_sparsity_2d_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ss2d_pkg::IDX_W-1:0] cfg_index,
  input  logic [ss2d_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ss2d_pkg::SP_W-1:0]  in_species,
  input  logic [ss2d_pkg::POS_W-1:0] in_x_pos,
  input  logic [ss2d_pkg::POS_W-1:0] in_y_pos,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ss2d_pkg::COL_W-1:0] out_column_index,
  output logic [ss2d_pkg::PTR_W-1:0] out_row_end_pointer,
  output logic                       out_overflow,
  output logic                       out_last
);
  import ss2d_pkg::*;

  logic [NS_W-1:0]  species_count_r;
  logic [DIM_W-1:0] x_size_r;
  logic [DIM_W-1:0] y_size_r;
  logic             wrap_x_r;
  logic             wrap_y_r;
  logic [PTR_W-1:0] capacity_r;
  logic [NT_W-1:0]  nt_r;

  cfg_t             cfg;
  logic [NS_W-1:0]  ns_c;
  logic [DIM_W-1:0] nx_c;
  logic [DIM_W-1:0] ny_c;
  logic [2*DIM_W-1:0] nt_full;

  logic             q_full;
  logic             q_push;
  entry_t           q_wdata;
  logic             q_valid;
  logic             q_pop;
  entry_t           q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      species_count_r <= NS_W'(1);
      x_size_r        <= DIM_W'(1);
      y_size_r        <= DIM_W'(1);
      wrap_x_r        <= 1'b0;
      wrap_y_r        <= 1'b0;
      capacity_r      <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPECIES:  species_count_r <= cfg_data[NS_W-1:0];
        REG_X_SIZE:   x_size_r        <= cfg_data[DIM_W-1:0];
        REG_Y_SIZE:   y_size_r        <= cfg_data[DIM_W-1:0];
        REG_WRAP_X:   wrap_x_r        <= cfg_data[0];
        REG_WRAP_Y:   wrap_y_r        <= cfg_data[0];
        REG_CAPACITY: capacity_r      <= cfg_data[PTR_W-1:0];
        default: ;
      endcase
    end
    // grid size product, registered; only read once a cell has passed the front end register
    nt_r <= nt_full[NT_W-1:0];
  end

  always_comb begin
    if (species_count_r == '0) ns_c = NS_W'(1);
    else if (species_count_r > NS_W'(MAX_SPECIES)) ns_c = NS_W'(MAX_SPECIES);
    else ns_c = species_count_r;
    if (x_size_r == '0) nx_c = DIM_W'(1);
    else if (x_size_r > DIM_W'(MAX_DIM)) nx_c = DIM_W'(MAX_DIM);
    else nx_c = x_size_r;
    if (y_size_r == '0) ny_c = DIM_W'(1);
    else if (y_size_r > DIM_W'(MAX_DIM)) ny_c = DIM_W'(MAX_DIM);
    else ny_c = y_size_r;
    nt_full = (2*DIM_W)'(nx_c) * (2*DIM_W)'(ny_c);

    cfg.ns     = ns_c;
    cfg.nx     = nx_c;
    cfg.ny     = ny_c;
    cfg.wrap_x = wrap_x_r;
    cfg.wrap_y = wrap_y_r;
    cfg.cap    = capacity_r;
    cfg.nt     = nt_r;
  end

  ss2d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_species (in_species),
    .in_x_pos   (in_x_pos),
    .in_y_pos   (in_y_pos),
    .in_restart (in_restart),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  ss2d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  ss2d_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .q_valid             (q_valid),
    .q_data              (q_rdata),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_column_index    (out_column_index),
    .out_row_end_pointer (out_row_end_pointer),
    .out_overflow        (out_overflow),
    .out_last            (out_last)
  );

endmodule

// ===== src/ss2d_checker.sv =====
// port-level checks of the stencil sparsity generator and their bind
module ss2d_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ss2d_pkg::COL_W-1:0] out_column_index,
  input logic [ss2d_pkg::PTR_W-1:0] out_row_end_pointer,
  input logic                       out_overflow,
  input logic                       out_last
);

  // overflow is a single closing result with no column
  a_ovf_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last && (out_column_index == '0))
    else $error("overflow result not last or has a column");

  // row end pointer only on the closing result of a cell
  a_ptr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_row_end_pointer == '0)
    else $error("row end pointer on a non-final result");

  // a closing result always carries a pointer of at least one
  a_ptr_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row_end_pointer != '0)
    else $error("final result without row end pointer");

  // columns are 1-based
  a_col_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_column_index != '0)
    else $error("zero column index");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_column_index) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind stencil_sparsity_2d_unit ss2d_checker u_ss2d_checker (.*);
